[rtl/core/sphere_span_shader_macros.svh]
// ----------------------------------------------------------------------------
// sphere span shader assertion macros
// concurrent check helpers, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef SPHERE_SPAN_SHADER_MACROS_SVH
`define SPHERE_SPAN_SHADER_MACROS_SVH
`ifndef SYNTHESIS
`define SSS_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("sss assertion failed");
`define SSS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sss implication failed");
`else
`define SSS_ASSERT(lbl, cond)
`define SSS_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

[rtl/core/sss_pkg.sv]
// ----------------------------------------------------------------------------
// sss_pkg
// shared types, register indexes and glyph table of the sphere span shader
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam logic [2:0] CFG_CENTER_X  = 3'd0;
    localparam logic [2:0] CFG_CENTER_Y  = 3'd1;
    localparam logic [2:0] CFG_RADIUS    = 3'd2;
    localparam logic [2:0] CFG_ROTATION  = 3'd3;
    localparam logic [2:0] CFG_ELEVATION = 3'd4;

    localparam int GLYPH_COLS = 19;
    localparam int GLYPH_ROWS = 5;

    // leftmost column in the top bit
    localparam logic [18:0] GLYPH [GLYPH_ROWS] = '{
        19'b1110110011101110111,
        19'b1010101010000010001,
        19'b1110110010101110111,
        19'b1000101010100010100,
        19'b1000101011101110111
    };

    typedef struct packed {
        logic signed [6:0] py;
        logic [6:0]        xr;
    } t_job;

    function automatic logic glyph_bit(input logic [2:0] row, input logic [4:0] col);
        logic [4:0] bitpos;
        bitpos = 5'(GLYPH_COLS - 1) - col;
        return GLYPH[row][bitpos];
    endfunction

endpackage

[rtl/core/sss_isqrt.sv]
// ----------------------------------------------------------------------------
// sss_isqrt
// iterative integer square root of a 16-bit value, two bits per cycle
// ----------------------------------------------------------------------------
module sss_isqrt
    import sss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_n,
    output logic        o_done,
    output logic [7:0]  o_root
);

    logic        r_busy;
    logic        r_done;
    logic [2:0]  r_cnt;
    logic [15:0] r_num;
    logic [15:0] r_root;
    logic [15:0] r_bit;
    logic [15:0] w_sum;
    logic        w_ge;

    assign w_sum = r_root + r_bit;
    assign w_ge  = r_num >= w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_n;
            r_root <= '0;
            r_bit  <= 16'h4000;
        end else if (r_busy) begin
            if (w_ge) begin
                r_num  <= r_num - w_sum;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root[7:0];

endmodule

[rtl/core/sss_queue.sv]
// ----------------------------------------------------------------------------
// sss_queue
// two-entry job queue between the row front end and the sample back end
// ----------------------------------------------------------------------------
module sss_queue
    import sss_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assign o_job   = r_mem[r_rp];
    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;

endmodule

[rtl/core/sss_front.sv]
// ----------------------------------------------------------------------------
// sss_front
// takes row offsets, drops rows off the sphere or with zero radius, finds the half width
// ----------------------------------------------------------------------------
module sss_front
    import sss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic signed [6:0] i_row_offset,
    input  logic [5:0]        i_radius,
    output logic              o_push,
    output t_job              o_job,
    input  logic              i_full
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_SQRT = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]        r_state;
    logic signed [6:0] r_py;
    logic [6:0]        r_xr;
    logic [15:0]       w_r2;
    logic [15:0]       w_py2;
    logic [6:0]        w_pya;
    logic              w_take;
    logic              w_keep;
    logic              w_done;
    logic [7:0]        w_root;

    assign w_pya  = i_row_offset[6] ? 7'(-i_row_offset) : 7'(i_row_offset);
    assign w_r2   = 16'(i_radius) * 16'(i_radius);
    assign w_py2  = 16'(w_pya) * 16'(w_pya);
    assign o_ready = r_state == F_IDLE;
    assign w_take = i_valid && o_ready;
    assign w_keep = (i_radius != 6'd0) && (w_py2 <= w_r2);

    sss_isqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_take && w_keep),
        .i_n     (w_r2 - w_py2),
        .o_done  (w_done),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: if (w_take && w_keep) r_state <= F_SQRT;
                F_SQRT: if (w_done) r_state <= F_PUSH;
                F_PUSH: if (!i_full) r_state <= F_IDLE;
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) r_py <= i_row_offset;
        if (r_state == F_SQRT && w_done) r_xr <= w_root[6:0];
    end

    assign o_push   = (r_state == F_PUSH) && !i_full;
    assign o_job.py = r_py;
    assign o_job.xr = r_xr;

endmodule

[rtl/core/sss_back.sv]
// ----------------------------------------------------------------------------
// sss_back
// walks the samples of a row, shades each one and merges them into runs
// ----------------------------------------------------------------------------
module sss_back
    import sss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_avail,
    input  t_job              i_job,
    output logic              o_pop,
    input  logic [8:0]        i_center_x,
    input  logic [7:0]        i_center_y,
    input  logic [5:0]        i_radius,
    input  logic [6:0]        i_rotation,
    input  logic signed [6:0] i_elevation,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [9:0]        o_run_start_x,
    output logic [9:0]        o_run_row_y,
    output logic [6:0]        o_run_length,
    output logic [5:0]        o_color_index,
    output logic              o_last_in_row
);

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_SQRT  = 3'd1;
    localparam logic [2:0] B_DIV   = 3'd2;
    localparam logic [2:0] B_IDX   = 3'd3;
    localparam logic [2:0] B_MERGE = 3'd4;
    localparam logic [2:0] B_FINAL = 3'd5;

    logic [2:0]         r_state;
    logic [3:0]         r_dcnt;
    logic               r_first;
    logic signed [6:0]  r_py;
    logic [6:0]         r_xr;
    logic signed [8:0]  r_px;
    logic signed [8:0]  r_run_px;
    logic [5:0]         r_run_idx;
    logic [5:0]         r_idx;
    logic [15:0]        r_n1, r_n2, r_q1, r_q2;
    logic [9:0]         r_rm1, r_rm2;
    logic [8:0]         r_den1, r_den2;
    logic               r_neg1, r_neg2;
    logic signed [15:0] r_v;

    // sample depth
    logic [7:0]         w_z;
    logic               w_sq_done;
    logic               w_sq_start;
    logic signed [8:0]  w_px_start;
    logic [7:0]         w_pxa_start;
    logic [15:0]        w_n;
    logic [15:0]        w_r2, w_py2, w_px2;
    logic [6:0]         w_pya;

    // prep
    logic [7:0]         w_pxa;
    logic signed [10:0] w_lt;
    logic [9:0]         w_lta;
    logic signed [15:0] w_ev;

    // divider steps
    logic [9:0]         w_t1, w_t2;
    logic               w_ge1, w_ge2;

    // index
    logic signed [16:0] w_q1s, w_q2s, w_u, w_light;
    logic [7:0]         w_lclamp;
    logic [16:0]        w_a;
    logic signed [7:0]  w_tc;
    logic signed [15:0] w_tv;
    logic [4:0]         w_col;
    logic [2:0]         w_row;
    logic               w_hit;
    logic [1:0]         w_fam;

    logic               w_out_free;
    logic               w_change;
    logic               w_at_end;
    logic               w_emit;

    assign o_pop      = (r_state == B_IDLE) && i_avail;
    assign w_out_free = !o_valid || i_ready;

    // next sample position: first sample of a new job or px + 2
    assign w_px_start  = (r_state == B_IDLE) ? -$signed({2'b00, i_job.xr})
                                             : r_px + 9'sd2;
    assign w_pxa_start = w_px_start[8] ? 8'(-w_px_start) : w_px_start[7:0];
    assign w_pya       = (r_state == B_IDLE) ?
                         (i_job.py[6] ? 7'(-i_job.py) : 7'(i_job.py)) :
                         (r_py[6] ? 7'(-r_py) : 7'(r_py));
    assign w_r2  = 16'(i_radius) * 16'(i_radius);
    assign w_py2 = 16'(w_pya) * 16'(w_pya);
    assign w_px2 = 16'(w_pxa_start) * 16'(w_pxa_start);
    assign w_n   = w_r2 - w_py2 - w_px2;

    assign w_at_end   = (r_px + 9'sd2) > $signed({2'b00, r_xr});
    assign w_change   = !r_first && (r_idx != r_run_idx);
    assign w_sq_start = o_pop ||
                        (r_state == B_MERGE && !w_at_end && (!w_change || w_out_free));
    assign w_emit     = w_out_free &&
                        ((r_state == B_MERGE && w_change) || r_state == B_FINAL);

    sss_isqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_n     (w_n),
        .o_done  (w_sq_done),
        .o_root  (w_z)
    );

    // numerators and divisors from the fresh depth
    assign w_pxa = r_px[8] ? 8'(-r_px) : r_px[7:0];
    assign w_lt  = -11'(r_px) - 11'(r_py) + $signed({2'b00, w_z, 1'b0});
    assign w_lta = w_lt[10] ? 10'(-w_lt) : w_lt[9:0];
    assign w_ev  = 16'(i_elevation) * $signed({8'b0, w_z});

    assign w_t1  = {r_rm1[8:0], r_n1[15]};
    assign w_t2  = {r_rm2[8:0], r_n2[15]};
    assign w_ge1 = w_t1 >= {1'b0, r_den1};
    assign w_ge2 = w_t2 >= {1'b0, r_den2};

    // truncating quotients, then texture and light
    assign w_q1s    = r_neg1 ? -$signed({1'b0, r_q1}) : $signed({1'b0, r_q1});
    assign w_q2s    = r_neg2 ? -$signed({1'b0, r_q2}) : $signed({1'b0, r_q2});
    assign w_u      = $signed({10'b0, i_rotation}) + w_q1s;
    assign w_light  = 17'sd120 + w_q2s;
    assign w_lclamp = (w_light < 17'sd58)  ? 8'd58 :
                      (w_light > 17'sd255) ? 8'd255 : w_light[7:0];

    // glyph lookup: column from the wrapped texture u, row from v
    assign w_a   = 17'(w_u) + 17'd140;
    assign w_tc  = $signed({1'b0, w_a[6:0]}) - 8'sd26;
    assign w_tv  = r_v + 16'sd10;
    assign w_col = w_tc[7] ? 5'd0 : w_tc[6:2];
    assign w_row = w_tv[15] ? 3'd0 : w_tv[4:2];
    assign w_hit = (w_tc >= -8'sd3) && (w_col < 5'(GLYPH_COLS)) &&
                   (w_tv >= -16'sd3) && (w_tv < 16'sd20) &&
                   glyph_bit(w_row, w_col);
    assign w_fam = w_hit ? 2'd2 : {1'b0, w_u[4] ^ r_v[4]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE:  if (o_pop) r_state <= B_SQRT;
                B_SQRT:  if (w_sq_done) r_state <= B_DIV;
                B_DIV:   if (r_dcnt == 4'd15) r_state <= B_IDX;
                B_IDX:   r_state <= B_MERGE;
                B_MERGE: begin
                    if (!w_change || w_out_free) begin
                        r_state <= w_at_end ? B_FINAL : B_SQRT;
                    end
                end
                B_FINAL: begin
                    if (w_out_free) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_py    <= i_job.py;
            r_xr    <= i_job.xr;
            r_first <= 1'b1;
        end
        if (w_sq_start) r_px <= w_px_start;

        if (r_state == B_SQRT && w_sq_done) begin
            r_dcnt <= '0;
            r_rm1  <= '0;
            r_rm2  <= '0;
            r_n1   <= 16'(w_pxa) * 16'd96;
            r_neg1 <= r_px[8];
            r_den1 <= 9'(w_z) + 9'(i_radius) + 9'd1;
            r_n2   <= 16'(w_lta) * 16'd90;
            r_neg2 <= w_lt[10];
            r_den2 <= {1'b0, i_radius, 2'b00};
            r_v    <= 16'(r_py) + (w_ev >>> 7) + 16'sd24;
        end

        if (r_state == B_DIV) begin
            r_dcnt <= r_dcnt + 4'd1;
            r_n1   <= r_n1 << 1;
            r_n2   <= r_n2 << 1;
            r_rm1  <= w_ge1 ? w_t1 - {1'b0, r_den1} : w_t1;
            r_rm2  <= w_ge2 ? w_t2 - {1'b0, r_den2} : w_t2;
            r_q1   <= {r_q1[14:0], w_ge1};
            r_q2   <= {r_q2[14:0], w_ge2};
        end

        if (r_state == B_IDX) r_idx <= {1'b1, w_fam, w_lclamp[7:5]};

        if (r_state == B_MERGE && (!w_change || w_out_free)) begin
            if (w_change) begin
                o_run_start_x <= 10'(i_center_x) + 10'(r_run_px);
                o_run_row_y   <= 10'(i_center_y) + 10'(r_py);
                o_run_length  <= 7'(r_px - r_run_px);
                o_color_index <= r_run_idx;
                o_last_in_row <= 1'b0;
            end
            if (r_first || w_change) begin
                r_run_px  <= r_px;
                r_run_idx <= r_idx;
            end
            r_first <= 1'b0;
        end

        if (r_state == B_FINAL && w_out_free) begin
            o_run_start_x <= 10'(i_center_x) + 10'(r_run_px);
            o_run_row_y   <= 10'(i_center_y) + 10'(r_py);
            o_run_length  <= 7'($signed({2'b00, r_xr}) - r_run_px + 9'sd1);
            o_color_index <= r_run_idx;
            o_last_in_row <= 1'b1;
        end
    end

endmodule

[rtl/core/sphere_span_shader.sv]
// ----------------------------------------------------------------------------
// sphere_span_shader
// one row offset in, the row's shaded sphere runs out
// ----------------------------------------------------------------------------
// The front end runs an iterative root for the half width of a row that lies
// on the sphere, then pushes the job into the queue; a row that is dropped
// takes no root. The back end then walks xr + 1 samples per row, two pixels
// apart, in turn: an iterative root for the depth, a restoring divider pair
// for texture u and light, then index and merge steps; a final step closes
// the row, and a run waiting at the output holds the back end until its
// transfer. The queue holds up to two rows ahead so new offsets keep coming
// in while the back end is busy; rows off the sphere or with zero radius give
// no runs. Runs come out left to right, the last one of each row flagged.
`include "sphere_span_shader_macros.svh"

module sphere_span_shader
    import sss_pkg::*;
#(
    parameter int MAX_RADIUS = 63
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic signed [6:0] i_row_offset,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [9:0]        o_run_start_x,
    output logic [9:0]        o_run_row_y,
    output logic [6:0]        o_run_length,
    output logic [5:0]        o_color_index,
    output logic              o_last_in_row,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [8:0]        i_cfg_data
);

    localparam logic [6:0] MAXR = 7'(MAX_RADIUS);

    logic [8:0]        r_center_x;
    logic [7:0]        r_center_y;
    logic [5:0]        r_radius;
    logic [6:0]        r_rotation;
    logic signed [6:0] r_elevation;
    logic [5:0]        w_radius;
    logic              w_push, w_pop, w_full, w_empty;
    t_job              w_job_in, w_job_out;

    assign o_cfg_ready = 1'b1;
    assign w_radius = ({1'b0, r_radius} > MAXR) ? MAXR[5:0] : r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x  <= 9'd160;
            r_center_y  <= 8'd80;
            r_radius    <= 6'd43;
            r_rotation  <= 7'd0;
            r_elevation <= -7'sd18;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CENTER_X:  r_center_x  <= i_cfg_data;
                CFG_CENTER_Y:  r_center_y  <= i_cfg_data[7:0];
                CFG_RADIUS:    r_radius    <= i_cfg_data[5:0];
                CFG_ROTATION:  r_rotation  <= i_cfg_data[6:0];
                CFG_ELEVATION: r_elevation <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    sss_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_row_offset (i_row_offset),
        .i_radius     (w_radius),
        .o_push       (w_push),
        .o_job        (w_job_in),
        .i_full       (w_full)
    );

    sss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_empty (w_empty)
    );

    sss_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_avail       (!w_empty),
        .i_job         (w_job_out),
        .o_pop         (w_pop),
        .i_center_x    (r_center_x),
        .i_center_y    (r_center_y),
        .i_radius      (w_radius),
        .i_rotation    (r_rotation),
        .i_elevation   (r_elevation),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_run_start_x (o_run_start_x),
        .o_run_row_y   (o_run_row_y),
        .o_run_length  (o_run_length),
        .o_color_index (o_color_index),
        .o_last_in_row (o_last_in_row)
    );

    `SSS_ASSERT_IMP(a_no_pop_empty, w_pop, !w_empty)
    `SSS_ASSERT_IMP(a_no_push_full, w_push, !w_full)
    `SSS_ASSERT_IMP(a_index_range, o_valid, o_color_index >= 6'd32 && o_color_index <= 6'd55)
    `SSS_ASSERT_IMP(a_run_nonzero, o_valid, o_run_length != 7'd0)

endmodule
